>>> src/gif_lzw_frame_decoder_top_defines.svh
// Assertion helpers for the decoder top
`ifndef GIF_LZW_FRAME_DECODER_TOP_DEFINES_SVH
`define GIF_LZW_FRAME_DECODER_TOP_DEFINES_SVH

// Property that must hold at every clock edge outside reset
`define GLD_ASSERT(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("gld assertion failed");

// Condition that must hold in the cycle after a trigger
`define GLD_ASSERT_NEXT(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("gld assertion failed");

`endif

>>> src/gld_pkg.sv
package gld_pkg;

   // sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_INIT,
      S_MUL,
      S_CHK,
      S_DEC,
      S_FIRST,
      S_WALK,
      S_WALKD,
      S_LAST,
      S_ILACE,
      S_POPR,
      S_POPM
   } state_type;

   // decoder phase
   typedef enum logic [1:0] {
      PH_IDLE,
      PH_RUN,
      PH_DONE,
      PH_ERR
   } phase_type;

   // status codes of a result
   localparam logic [1:0] STAT_RUN  = 2'd0;
   localparam logic [1:0] STAT_NEED = 2'd1;
   localparam logic [1:0] STAT_DONE = 2'd2;
   localparam logic [1:0] STAT_ERR  = 2'd3;

   // request actions
   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_PUSH  = 2'd1;
   localparam logic [1:0] ACT_STEP  = 2'd2;

   // register indexes
   localparam logic [2:0] CFG_LEFT   = 3'd0;
   localparam logic [2:0] CFG_TOP    = 3'd1;
   localparam logic [2:0] CFG_COLS   = 3'd2;
   localparam logic [2:0] CFG_ROWS   = 3'd3;
   localparam logic [2:0] CFG_STRIDE = 3'd4;
   localparam logic [2:0] CFG_TRANS  = 3'd5;
   localparam logic [2:0] CFG_SKIP   = 3'd6;
   localparam logic [2:0] CFG_INTER  = 3'd7;

   // previous code after a clear
   localparam logic [12:0] NULL_CODE = 13'h1FFF;
   // largest code size allowed at start
   localparam logic [7:0] MAX_ROOT = 8'd12;

   function automatic logic [1:0] phase_status(input phase_type ph);
      logic [1:0] s;
      case (ph)
         PH_RUN:  s = STAT_RUN;
         PH_ERR:  s = STAT_ERR;
         default: s = STAT_DONE;
      endcase
      return s;
   endfunction

endpackage

>>> src/gld_mult.sv
// Shared multiplier: frame pixel count and row address, product registered
module gld_mult (
   input  logic        clock,
   input  logic [17:0] mul_a,
   input  logic [15:0] mul_b,
   output logic [33:0] mul_p
);
   logic [33:0] prod_ff;
   logic [33:0] prod_in;

   assign prod_in = 34'(mul_a) * 34'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_p = prod_ff;
endmodule

>>> src/gif_lzw_frame_decoder_top.sv
// Start runs S_EXEC, then S_INIT (root sweep); push and ignored actions run S_EXEC only.
// Step: S_MUL and S_CHK, then a pixel pop (S_POPR, S_POPM; S_ILACE on interlace pass changes)
// or a decode (S_DEC, then S_FIRST or S_WALK/S_WALKD per chain symbol and S_LAST).
// Throughput: one request at a time; the next is taken once the result register is free.
// Reset: synchronous, active high; clears control and configuration registers; payload,
// dictionary and pixel stack contents stay undefined until written.
module gif_lzw_frame_decoder_top #(
   parameter int DICT_DEPTH  = 4096,
   parameter int STACK_DEPTH = 8192,
   parameter int ADDR_BITS   = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [1:0] action, [9:2] data_byte
   input  logic [15:0]                           req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [ADDR_BITS-1:0] pixel_address, then color_index
   output logic [((ADDR_BITS+8+7)/8)*8-1:0]      rsp_tdata,
   // [0] pixel_valid, [2:1] status
   output logic [2:0]                            rsp_tuser,
   input  logic                                  csr_we,
   input  logic [2:0]                            csr_index,
   input  logic [15:0]                           csr_wdata
);
   import gld_pkg::*;
   `include "gif_lzw_frame_decoder_top_defines.svh"

   localparam int DBITS  = $clog2(DICT_DEPTH);
   localparam int SBITS  = $clog2(STACK_DEPTH);
   localparam int TDW    = ((ADDR_BITS+8+7)/8)*8;
   localparam logic [12:0] DICT_LIM = 13'(DICT_DEPTH);
   localparam logic [11:0] DICT_MSK = 12'(DICT_DEPTH - 1);
   localparam logic [SBITS:0] STK_LIM = (SBITS+1)'(STACK_DEPTH);
   localparam logic [SBITS:0] STK_MSK = (SBITS+1)'(STACK_DEPTH - 1);

   // configuration
   logic [15:0] left_ff, top_ff, cols_ff, rows_ff, stride_ff;
   logic [7:0]  trans_ff;
   logic        skip_ff, inter_ff;

   // control and decoder state
   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic [1:0]  act_ff, act_in;
   logic [7:0]  byte_ff, byte_in;
   logic [SBITS:0] stk_top_ff, stk_top_in;
   logic [23:0] bbuf_ff, bbuf_in;
   logic [4:0]  bcnt_ff, bcnt_in;
   logic [3:0]  root_ff, root_in;
   logic [3:0]  cw_ff, cw_in;
   logic [12:0] nfc_ff, nfc_in;
   logic [12:0] prev_ff, prev_in;
   logic [7:0]  first_ff, first_in;
   logic [7:0]  sub_ff, sub_in;
   logic [31:0] pdone_ff, pdone_in;
   logic [16:0] col_ff, col_in;
   logic [17:0] row_ff, row_in;
   logic [2:0]  pass_ff, pass_in;
   logic [3:0]  rstep_ff, rstep_in;
   logic        ended_ff, ended_in;
   logic [11:0] code_ff, code_in;
   logic [11:0] incode_ff, incode_in;
   logic [11:0] walk_ff, walk_in;
   logic [11:0] init_ff, init_in;

   // result register
   logic                 rvalid_ff, rvalid_in;
   logic                 rpv_ff;
   logic [ADDR_BITS-1:0] raddr_ff;
   logic [7:0]           rcolor_ff;
   logic [1:0]           rstat_ff;
   logic                 fin;
   logic                 fin_pv;
   logic [ADDR_BITS-1:0] fin_addr;
   logic [7:0]           fin_color;
   logic [1:0]           fin_stat;

   // memories
   logic [11:0] prefix_mem [DICT_DEPTH];
   logic [7:0]  suffix_mem [DICT_DEPTH];
   logic [7:0]  stack_mem  [STACK_DEPTH];
   logic             dict_we;
   logic [DBITS-1:0] dict_waddr, dict_raddr;
   logic [11:0]      dict_wpre;
   logic [7:0]       dict_wsuf;
   logic [11:0]      pre_rd_ff;
   logic [7:0]       suf_rd_ff;
   logic             stk_we;
   logic [SBITS-1:0] stk_waddr, stk_raddr;
   logic [7:0]       stk_wdata;
   logic [7:0]       stk_rd_ff;

   // shared multiplier
   logic [17:0] mul_a;
   logic [15:0] mul_b;
   logic [33:0] mul_p;

   gld_mult u_mult (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   // derived values
   logic        accept;
   logic [12:0] clr, mask13, nfc_nx;
   logic [16:0] end_x, end_y;
   logic [11:0] code_now;
   logic        chk_done, chk_empty, chk_short, pop_wrap;
   logic        ilace_more, dec_big, dec_end, dec_clr, dec_first;
   logic        walk_more, stk_full, start_bad, init_last;
   logic        in_frame, pix_write;
   logic [12:0] start_clr;
   logic [SBITS:0] stk_dec;
   logic [34:0] addr_sum;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE) && (!rvalid_ff || rsp_tready);
   assign clr        = 13'd1 << root_ff;
   assign mask13     = (13'd1 << cw_ff) - 13'd1;
   assign nfc_nx     = nfc_ff + 13'd1;
   assign end_x      = 17'(left_ff) + 17'(cols_ff);
   assign end_y      = 17'(top_ff) + 17'(rows_ff);
   assign code_now   = 12'(bbuf_ff & 24'(mask13));
   assign chk_done   = pdone_ff >= mul_p[31:0];
   assign chk_empty  = stk_top_ff == '0;
   assign chk_short  = bcnt_ff < 5'(cw_ff);
   assign pop_wrap   = col_ff == end_x;
   assign ilace_more = (row_ff >= 18'(end_y)) && (pass_ff < 3'd5);
   assign dec_big    = 13'(code_ff) >= DICT_LIM;
   assign dec_end    = 13'(code_ff) == clr + 13'd1;
   assign dec_clr    = 13'(code_ff) == clr;
   assign dec_first  = prev_ff == NULL_CODE;
   assign walk_more  = 13'(walk_ff) > clr;
   assign stk_full   = stk_top_ff >= STK_LIM;
   assign start_clr  = 13'd1 << byte_ff[3:0];
   assign start_bad  = (byte_ff > MAX_ROOT) || (start_clr >= DICT_LIM);
   assign init_last  = 13'(init_ff) == clr - 13'd1;
   assign stk_dec    = stk_top_ff - (SBITS+1)'(1);
   assign in_frame   = (row_ff < 18'(end_y)) && (col_ff < end_x);
   assign pix_write  = in_frame && (!skip_ff || stk_rd_ff != trans_ff);
   assign addr_sum   = 35'(col_ff) + 35'(mul_p);

   // multiplier operands
   always_comb begin
      if (state_ff == S_POPR) begin
         mul_a = row_ff;
         mul_b = stride_ff;
      end else begin
         mul_a = 18'(cols_ff);
         mul_b = rows_ff;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (accept) state_in = S_EXEC;
         S_EXEC: begin
            if (act_ff == ACT_START) begin
               state_in = start_bad ? S_IDLE : S_INIT;
            end else if (act_ff == ACT_STEP && phase_ff == PH_RUN) begin
               state_in = S_MUL;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_INIT:  if (init_last) state_in = S_IDLE;
         S_MUL:   state_in = S_CHK;
         S_CHK: begin
            if (chk_done) begin
               state_in = S_IDLE;
            end else if (chk_empty) begin
               state_in = chk_short ? S_IDLE : S_DEC;
            end else if (pop_wrap && inter_ff) begin
               state_in = S_ILACE;
            end else begin
               state_in = S_POPR;
            end
         end
         S_DEC: begin
            if (dec_big || dec_end || dec_clr) begin
               state_in = S_IDLE;
            end else if (dec_first) begin
               state_in = S_FIRST;
            end else begin
               state_in = S_WALK;
            end
         end
         S_FIRST: state_in = S_IDLE;
         S_WALK: begin
            if (walk_more) begin
               state_in = stk_full ? S_IDLE : S_WALKD;
            end else begin
               state_in = S_LAST;
            end
         end
         S_WALKD: state_in = S_WALK;
         S_LAST:  state_in = S_IDLE;
         S_ILACE: if (!ilace_more) state_in = S_POPR;
         S_POPR:  state_in = S_POPM;
         S_POPM:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      act_in     = act_ff;
      byte_in    = byte_ff;
      phase_in   = phase_ff;
      stk_top_in = stk_top_ff;
      bbuf_in    = bbuf_ff;
      bcnt_in    = bcnt_ff;
      root_in    = root_ff;
      cw_in      = cw_ff;
      nfc_in     = nfc_ff;
      prev_in    = prev_ff;
      first_in   = first_ff;
      sub_in     = sub_ff;
      pdone_in   = pdone_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      pass_in    = pass_ff;
      rstep_in   = rstep_ff;
      ended_in   = ended_ff;
      code_in    = code_ff;
      incode_in  = incode_ff;
      walk_in    = walk_ff;
      init_in    = init_ff;
      fin        = 1'b0;
      fin_pv     = 1'b0;
      fin_addr   = '0;
      fin_color  = '0;
      fin_stat   = phase_status(phase_ff);
      dict_we    = 1'b0;
      dict_waddr = init_ff[DBITS-1:0];
      dict_wpre  = '0;
      dict_wsuf  = init_ff[7:0];
      dict_raddr = walk_ff[DBITS-1:0];
      stk_we     = 1'b0;
      stk_waddr  = stk_top_ff[SBITS-1:0];
      stk_wdata  = suf_rd_ff;
      stk_raddr  = stk_dec[SBITS-1:0] & STK_MSK[SBITS-1:0];
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               act_in  = req_tdata[1:0];
               byte_in = req_tdata[9:2];
            end
         end
         S_EXEC: begin
            case (act_ff)
               ACT_START: begin
                  stk_top_in = '0;
                  bbuf_in    = '0;
                  bcnt_in    = '0;
                  sub_in     = '0;
                  pdone_in   = '0;
                  first_in   = '0;
                  ended_in   = 1'b0;
                  col_in     = 17'(left_ff);
                  row_in     = 18'(top_ff);
                  pass_in    = 3'd1;
                  rstep_in   = inter_ff ? 4'd8 : 4'd1;
                  prev_in    = NULL_CODE;
                  if (start_bad) begin
                     phase_in = PH_ERR;
                     fin      = 1'b1;
                     fin_stat = STAT_ERR;
                  end else begin
                     phase_in = PH_RUN;
                     root_in  = byte_ff[3:0];
                     cw_in    = byte_ff[3:0] + 4'd1;
                     nfc_in   = start_clr + 13'd2;
                     init_in  = '0;
                  end
               end
               ACT_PUSH: begin
                  fin = 1'b1;
                  if (phase_ff == PH_RUN && !ended_ff) begin
                     if (sub_ff == '0) begin
                        if (byte_ff == '0) ended_in = 1'b1;
                        else sub_in = byte_ff;
                     end else begin
                        sub_in = sub_ff - 8'd1;
                        if (bcnt_ff <= 5'd16) begin
                           bbuf_in = bbuf_ff | (24'(byte_ff) << bcnt_ff);
                           bcnt_in = bcnt_ff + 5'd8;
                        end
                     end
                  end
               end
               ACT_STEP: begin
                  if (phase_ff != PH_RUN) fin = 1'b1;
               end
               default: fin = 1'b1;
            endcase
         end
         S_INIT: begin
            dict_we = 1'b1;
            init_in = init_ff + 12'd1;
            if (init_last) begin
               fin      = 1'b1;
               fin_stat = STAT_RUN;
            end
         end
         S_CHK: begin
            if (chk_done) begin
               phase_in = PH_DONE;
               fin      = 1'b1;
               fin_stat = STAT_DONE;
            end else if (chk_empty) begin
               if (chk_short) begin
                  fin = 1'b1;
                  if (ended_ff) begin
                     phase_in = PH_DONE;
                     fin_stat = STAT_DONE;
                  end else begin
                     fin_stat = STAT_NEED;
                  end
               end else begin
                  code_in = code_now;
                  bbuf_in = bbuf_ff >> cw_ff;
                  bcnt_in = bcnt_ff - 5'(cw_ff);
               end
            end else if (pop_wrap) begin
               col_in = 17'(left_ff);
               row_in = row_ff + 18'(rstep_ff);
            end
         end
         S_DEC: begin
            dict_raddr = code_ff[DBITS-1:0];
            if (dec_big) begin
               phase_in = PH_ERR;
               fin      = 1'b1;
               fin_stat = STAT_ERR;
            end else if (dec_end) begin
               phase_in = PH_DONE;
               fin      = 1'b1;
               fin_stat = STAT_DONE;
            end else if (dec_clr) begin
               cw_in    = root_ff + 4'd1;
               nfc_in   = clr + 13'd2;
               prev_in  = NULL_CODE;
               fin      = 1'b1;
               fin_stat = STAT_RUN;
            end else if (!dec_first) begin
               incode_in = code_ff;
               if (13'(code_ff) >= nfc_ff) begin
                  stk_we     = 1'b1;
                  stk_waddr  = '0;
                  stk_wdata  = first_ff;
                  stk_top_in = (SBITS+1)'(1);
                  walk_in    = prev_ff[11:0];
               end else begin
                  stk_top_in = '0;
                  walk_in    = code_ff;
               end
            end
         end
         S_FIRST: begin
            stk_we     = 1'b1;
            stk_waddr  = '0;
            stk_top_in = (SBITS+1)'(1);
            prev_in    = 13'(code_ff);
            first_in   = code_ff[7:0];
            fin        = 1'b1;
            fin_stat   = STAT_RUN;
         end
         S_WALK: begin
            if (walk_more && stk_full) begin
               phase_in = PH_ERR;
               fin      = 1'b1;
               fin_stat = STAT_ERR;
            end
         end
         S_WALKD: begin
            stk_we     = 1'b1;
            stk_top_in = stk_top_ff + (SBITS+1)'(1);
            walk_in    = pre_rd_ff & DICT_MSK;
         end
         S_LAST: begin
            fin = 1'b1;
            if (stk_full) begin
               phase_in = PH_ERR;
               fin_stat = STAT_ERR;
            end else begin
               fin_stat   = STAT_RUN;
               first_in   = suf_rd_ff;
               stk_we     = 1'b1;
               stk_top_in = stk_top_ff + (SBITS+1)'(1);
               if (nfc_ff < DICT_LIM) begin
                  dict_we    = 1'b1;
                  dict_waddr = nfc_ff[DBITS-1:0];
                  dict_wpre  = prev_ff[11:0];
                  dict_wsuf  = suf_rd_ff;
                  nfc_in     = nfc_nx;
                  if ((nfc_nx & mask13) == '0 && nfc_nx < DICT_LIM) cw_in = cw_ff + 4'd1;
               end
               prev_in = 13'(incode_ff);
            end
         end
         S_ILACE: begin
            if (ilace_more) begin
               pass_in = pass_ff + 3'd1;
               case (pass_ff)
                  3'd1: row_in = 18'(top_ff) + 18'd4;
                  3'd2: begin
                     row_in   = 18'(top_ff) + 18'd2;
                     rstep_in = 4'd4;
                  end
                  3'd3: begin
                     row_in   = 18'(top_ff) + 18'd1;
                     rstep_in = 4'd2;
                  end
                  default: begin
                     row_in   = 18'(top_ff);
                     rstep_in = 4'd1;
                  end
               endcase
            end
         end
         S_POPR: begin
            stk_top_in = stk_dec;
            pdone_in   = pdone_ff + 32'd1;
         end
         S_POPM: begin
            fin      = 1'b1;
            fin_stat = STAT_RUN;
            if (pix_write) begin
               fin_pv    = 1'b1;
               fin_addr  = addr_sum[ADDR_BITS-1:0];
               fin_color = stk_rd_ff;
            end
            if (in_frame) col_in = col_ff + 17'd1;
         end
         default: ;
      endcase
   end

   assign rvalid_in = fin || (rvalid_ff && !rsp_tready);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         phase_ff   <= PH_IDLE;
         rvalid_ff  <= 1'b0;
         stk_top_ff <= '0;
         bbuf_ff    <= '0;
         bcnt_ff    <= '0;
         root_ff    <= '0;
         cw_ff      <= '0;
         nfc_ff     <= '0;
         prev_ff    <= NULL_CODE;
         first_ff   <= '0;
         sub_ff     <= '0;
         pdone_ff   <= '0;
         col_ff     <= '0;
         row_ff     <= '0;
         pass_ff    <= 3'd1;
         rstep_ff   <= 4'd1;
         ended_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         rvalid_ff  <= rvalid_in;
         stk_top_ff <= stk_top_in;
         bbuf_ff    <= bbuf_in;
         bcnt_ff    <= bcnt_in;
         root_ff    <= root_in;
         cw_ff      <= cw_in;
         nfc_ff     <= nfc_in;
         prev_ff    <= prev_in;
         first_ff   <= first_in;
         sub_ff     <= sub_in;
         pdone_ff   <= pdone_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         pass_ff    <= pass_in;
         rstep_ff   <= rstep_in;
         ended_ff   <= ended_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      act_ff    <= act_in;
      byte_ff   <= byte_in;
      code_ff   <= code_in;
      incode_ff <= incode_in;
      walk_ff   <= walk_in;
      init_ff   <= init_in;
      if (fin) begin
         rpv_ff    <= fin_pv;
         raddr_ff  <= fin_addr;
         rcolor_ff <= fin_color;
         rstat_ff  <= fin_stat;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         top_ff    <= '0;
         cols_ff   <= '0;
         rows_ff   <= '0;
         stride_ff <= 16'd1;
         trans_ff  <= '0;
         skip_ff   <= 1'b0;
         inter_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CFG_LEFT:   left_ff   <= csr_wdata;
            CFG_TOP:    top_ff    <= csr_wdata;
            CFG_COLS:   cols_ff   <= csr_wdata;
            CFG_ROWS:   rows_ff   <= csr_wdata;
            CFG_STRIDE: stride_ff <= csr_wdata;
            CFG_TRANS:  trans_ff  <= csr_wdata[7:0];
            CFG_SKIP:   skip_ff   <= csr_wdata[0];
            CFG_INTER:  inter_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // dictionary memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (dict_we) begin
         prefix_mem[dict_waddr] <= dict_wpre;
         suffix_mem[dict_waddr] <= dict_wsuf;
      end
      pre_rd_ff <= prefix_mem[dict_raddr];
      suf_rd_ff <= suffix_mem[dict_raddr];
   end

   // pixel stack memory
   always_ff @(posedge clock) begin
      if (stk_we) stack_mem[stk_waddr] <= stk_wdata;
      stk_rd_ff <= stack_mem[stk_raddr];
   end

   // result channel
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = TDW'({rcolor_ff, raddr_ff});
   assign rsp_tuser  = {rstat_ff, rpv_ff};

   `GLD_ASSERT(a_stack_bound, stk_top_ff <= STK_LIM)
   `GLD_ASSERT(a_blank_payload, !(rvalid_ff && !rpv_ff) || (raddr_ff == '0 && rcolor_ff == '0))
   `GLD_ASSERT_NEXT(a_busy_after_accept, accept, !req_tready)
   `GLD_ASSERT(a_width_bound, phase_ff != PH_RUN || cw_ff <= 4'd12)
   `GLD_ASSERT_NEXT(a_pixel_running, fin && fin_pv, rsp_tvalid && rsp_tuser[2:1] == STAT_RUN)
endmodule
